// ----- rtl/core/ttcc_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ttcc_pkg
// Shared types and codes for the two-tier centroid replacement cache: beat
// payloads, controller commands and datapath status.
// -----------------------------------------------------------------------------
package ttcc_pkg;

   // Operation codes of an input beat.
   localparam logic OP_CREATE = 1'b0;
   localparam logic OP_HIT    = 1'b1;

   // Result status codes.
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_MISS = 1'b1;

   // Configuration register indexes (byte address is four times the index).
   localparam int          CSR_ADDR_BITS       = 4;
   localparam logic [1:0]  REG_USE_RECENCY     = 2'd0;
   localparam logic [1:0]  REG_RECENT_LIMIT    = 2'd1;
   localparam logic [1:0]  REG_FREQUENT_LIMIT  = 2'd2;

   typedef struct packed {
      logic        op;
      logic [23:0] hit_cluster;
   } req_type;

   typedef struct packed {
      logic [23:0] cluster_number;
      logic [31:0] hit_count_now;
      logic        dropped_valid;
      logic [23:0] dropped_cluster;
      logic        status;
   } rsp_type;

   // Source of a list write.
   typedef enum logic [1:0] {
      SRC_RDATA,
      SRC_ENT,
      SRC_EV
   } src_type;

   // Update of the entry being pushed.
   typedef enum logic [1:0] {
      ENT_HOLD,
      ENT_FROM_R,
      ENT_FROM_F
   } ent_op_type;

   // Update of the entry evicted from the recency list.
   typedef enum logic [1:0] {
      EV_HOLD,
      EV_FROM_ENT,
      EV_FROM_R
   } ev_op_type;

   // Update of the discard report.
   typedef enum logic [1:0] {
      DROP_HOLD,
      DROP_FROM_F,
      DROP_FROM_EV
   } drop_op_type;

   typedef struct packed {
      logic        latch;
      logic        set_miss;
      logic        load_rsp;
      logic        r_rd;
      logic        r_wr;
      src_type     r_src;
      logic        f_rd;
      logic        f_wr;
      src_type     f_src;
      ent_op_type  ent_op;
      ev_op_type   ev_op;
      drop_op_type drop_op;
   } cmd_type;

   typedef struct packed {
      logic r_match;
      logic f_match;
      logic ev_ge;
      logic slot_free;
   } sts_type;

endpackage

// ----- rtl/core/ttcc_dpath.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ttcc_dpath
// Datapath: the two list memories, the working entries, the cluster number
// counter and the result register.
// -----------------------------------------------------------------------------
module ttcc_dpath #(
   parameter int RECENT_DEPTH   = 32,
   parameter int FREQUENT_DEPTH = 32,
   parameter int ID_BITS        = 24,
   parameter int COUNT_BITS     = 32,
   parameter int RAW            = 5,
   parameter int FAW            = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ttcc_pkg::req_type     req_data,
   input  ttcc_pkg::cmd_type     cmd,
   input  logic [RAW-1:0]        r_addr,
   input  logic [FAW-1:0]        f_addr,
   output ttcc_pkg::sts_type     sts,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output ttcc_pkg::rsp_type     rsp_data
);

   localparam int EW = ID_BITS + COUNT_BITS;

   logic [EW-1:0] r_mem [RECENT_DEPTH];
   logic [EW-1:0] f_mem [FREQUENT_DEPTH];
   logic [EW-1:0] r_rdata_ff;
   logic [EW-1:0] f_rdata_ff;
   logic [EW-1:0] r_wdata;
   logic [EW-1:0] f_wdata;

   logic [ID_BITS-1:0]    key_ff, key_in;
   logic [ID_BITS-1:0]    next_ff, next_in;
   logic [ID_BITS-1:0]    ent_id_ff, ent_id_in;
   logic [COUNT_BITS-1:0] ent_cnt_ff, ent_cnt_in;
   logic [ID_BITS-1:0]    ev_id_ff, ev_id_in;
   logic [COUNT_BITS-1:0] ev_cnt_ff, ev_cnt_in;
   logic                  drop_v_ff, drop_v_in;
   logic [ID_BITS-1:0]    drop_id_ff, drop_id_in;
   logic [23:0]           cnum_ff, cnum_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                  status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ttcc_pkg::rsp_type     rsp_ff, rsp_in;

   logic [ID_BITS-1:0]    r_id, f_id;
   logic [COUNT_BITS-1:0] r_cnt, f_cnt, r_inc, f_inc;

   assign r_id  = r_rdata_ff[EW-1:COUNT_BITS];
   assign r_cnt = r_rdata_ff[COUNT_BITS-1:0];
   assign f_id  = f_rdata_ff[EW-1:COUNT_BITS];
   assign f_cnt = f_rdata_ff[COUNT_BITS-1:0];

   // Saturating count increments.
   assign r_inc = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
   assign f_inc = (f_cnt == '1) ? f_cnt : f_cnt + 1'b1;

   // Status toward the controller.
   assign sts.r_match   = (r_id == key_ff);
   assign sts.f_match   = (f_id == key_ff);
   assign sts.ev_ge     = (ev_cnt_ff >= f_cnt);
   assign sts.slot_free = !rsp_valid_ff || !rsp_stall;

   // Write data selection for both lists.
   always_comb begin
      case (cmd.r_src)
         ttcc_pkg::SRC_ENT: r_wdata = {ent_id_ff, ent_cnt_ff};
         ttcc_pkg::SRC_EV:  r_wdata = {ev_id_ff, ev_cnt_ff};
         default:           r_wdata = r_rdata_ff;
      endcase
      case (cmd.f_src)
         ttcc_pkg::SRC_ENT: f_wdata = {ent_id_ff, ent_cnt_ff};
         ttcc_pkg::SRC_EV:  f_wdata = {ev_id_ff, ev_cnt_ff};
         default:           f_wdata = f_rdata_ff;
      endcase
   end

   // List memories with registered read data.
   always_ff @(posedge clock) begin
      if (cmd.r_wr) begin
         r_mem[r_addr] <= r_wdata;
      end
      if (cmd.r_rd) begin
         r_rdata_ff <= r_mem[r_addr];
      end
      if (cmd.f_wr) begin
         f_mem[f_addr] <= f_wdata;
      end
      if (cmd.f_rd) begin
         f_rdata_ff <= f_mem[f_addr];
      end
   end

   // Working registers and result slot.
   always_comb begin
      key_in       = key_ff;
      next_in      = next_ff;
      ent_id_in    = ent_id_ff;
      ent_cnt_in   = ent_cnt_ff;
      ev_id_in     = ev_id_ff;
      ev_cnt_in    = ev_cnt_ff;
      drop_v_in    = drop_v_ff;
      drop_id_in   = drop_id_ff;
      cnum_in      = cnum_ff;
      cnt_in       = cnt_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.latch) begin
         key_in     = ID_BITS'(req_data.hit_cluster);
         drop_v_in  = 1'b0;
         drop_id_in = '0;
         cnt_in     = '0;
         status_in  = ttcc_pkg::STATUS_DONE;
         if (req_data.op == ttcc_pkg::OP_CREATE) begin
            ent_id_in  = next_ff;
            ent_cnt_in = '0;
            cnum_in    = 24'(next_ff);
            next_in    = next_ff + 1'b1;
         end else begin
            cnum_in = req_data.hit_cluster;
         end
      end

      case (cmd.ent_op)
         ttcc_pkg::ENT_FROM_R: begin
            ent_id_in  = key_ff;
            ent_cnt_in = r_inc;
            cnt_in     = r_inc;
         end
         ttcc_pkg::ENT_FROM_F: begin
            ent_id_in  = key_ff;
            ent_cnt_in = f_inc;
            cnt_in     = f_inc;
         end
         default: ;
      endcase

      case (cmd.ev_op)
         ttcc_pkg::EV_FROM_ENT: begin
            ev_id_in  = ent_id_ff;
            ev_cnt_in = ent_cnt_ff;
         end
         ttcc_pkg::EV_FROM_R: begin
            ev_id_in  = r_id;
            ev_cnt_in = r_cnt;
         end
         default: ;
      endcase

      case (cmd.drop_op)
         ttcc_pkg::DROP_FROM_F: begin
            drop_v_in  = 1'b1;
            drop_id_in = f_id;
         end
         ttcc_pkg::DROP_FROM_EV: begin
            drop_v_in  = 1'b1;
            drop_id_in = ev_id_ff;
         end
         default: ;
      endcase

      if (cmd.set_miss) begin
         status_in = ttcc_pkg::STATUS_MISS;
      end

      if (cmd.load_rsp) begin
         rsp_in.cluster_number  = cnum_ff;
         rsp_in.hit_count_now   = 32'(cnt_ff);
         rsp_in.dropped_valid   = drop_v_ff;
         rsp_in.dropped_cluster = 24'(drop_id_ff);
         rsp_in.status          = status_ff;
         rsp_valid_in           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      ent_id_ff  <= ent_id_in;
      ent_cnt_ff <= ent_cnt_in;
      ev_id_ff   <= ev_id_in;
      ev_cnt_ff  <= ev_cnt_in;
      drop_v_ff  <= drop_v_in;
      drop_id_ff <= drop_id_in;
      cnum_ff    <= cnum_in;
      cnt_ff     <= cnt_in;
      status_ff  <= status_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         next_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         next_ff      <= next_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/core/ttcc_ctrl.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ttcc_ctrl
// Controller: sequences searches, removals, shifts and ordered inserts over
// the two lists, one memory access per list per cycle.
// -----------------------------------------------------------------------------
module ttcc_ctrl #(
   parameter int RECENT_DEPTH   = 32,
   parameter int FREQUENT_DEPTH = 32,
   parameter int RAW            = 5,
   parameter int FAW            = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_op,
   output logic                req_stall,
   input  logic                use_recency,
   input  logic [5:0]          recent_limit,
   input  logic [5:0]          frequent_limit,
   input  ttcc_pkg::sts_type   sts,
   output ttcc_pkg::cmd_type   cmd,
   output logic [RAW-1:0]      r_addr,
   output logic [FAW-1:0]      f_addr
);

   localparam int RCW = $clog2(RECENT_DEPTH + 1);
   localparam int FCW = $clog2(FREQUENT_DEPTH + 1);
   localparam int IW  = (RCW > FCW) ? RCW : FCW;

   typedef enum logic [4:0] {
      S_IDLE, S_RS_RD, S_RS_CHK, S_R_WB, S_RD_RD, S_RD_WR,
      S_FS_RD, S_FS_CHK, S_F_WB, S_FD_RD, S_FD_WR,
      S_PUSH, S_PE_CAP, S_SU_RD, S_SU_WR,
      S_FI_RD, S_FI_CHK, S_FI_PLACE, S_FI_DROP, S_FU_RD, S_FU_WR,
      S_DONE
   } state_type;

   state_type       state_ff, state_in;
   logic [IW-1:0]   i_ff, i_in;
   logic [FCW-1:0]  pos_ff, pos_in;
   logic [RCW-1:0]  rfill_ff, rfill_in;
   logic [FCW-1:0]  ffill_ff, ffill_in;
   logic            evict_ff, evict_in;
   logic            grow_ff, grow_in;
   logic [RCW-1:0]  rlim;
   logic [FCW-1:0]  flim;
   logic [IW-1:0]   rfill_x, ffill_x, i_up, i_dn;

   // Effective limits, capped at the list depths.
   assign rlim = (9'(recent_limit) > 9'(RECENT_DEPTH)) ? RCW'(RECENT_DEPTH)
                                                       : RCW'(recent_limit);
   assign flim = (9'(frequent_limit) > 9'(FREQUENT_DEPTH)) ? FCW'(FREQUENT_DEPTH)
                                                           : FCW'(frequent_limit);

   assign rfill_x = IW'(rfill_ff);
   assign ffill_x = IW'(ffill_ff);
   assign i_up    = i_ff + 1'b1;
   assign i_dn    = i_ff - 1'b1;

   assign req_stall = (state_ff != S_IDLE);

   // Next state and per-cycle commands.
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      pos_in   = pos_ff;
      rfill_in = rfill_ff;
      ffill_in = ffill_ff;
      evict_in = evict_ff;
      grow_in  = grow_ff;
      cmd      = '0;
      r_addr   = RAW'(i_ff);
      f_addr   = FAW'(i_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               i_in      = '0;
               state_in  = (req_op == ttcc_pkg::OP_CREATE) ? S_PUSH : S_RS_RD;
            end
         end

         // Search the recency list for the hit key.
         S_RS_RD: begin
            if (i_ff >= rfill_x) begin
               i_in     = '0;
               state_in = S_FS_RD;
            end else begin
               cmd.r_rd = 1'b1;
               state_in = S_RS_CHK;
            end
         end
         S_RS_CHK: begin
            if (sts.r_match) begin
               cmd.ent_op = ttcc_pkg::ENT_FROM_R;
               state_in   = use_recency ? S_RD_RD : S_R_WB;
            end else begin
               i_in     = i_up;
               state_in = S_RS_RD;
            end
         end
         S_R_WB: begin
            cmd.r_wr  = 1'b1;
            cmd.r_src = ttcc_pkg::SRC_ENT;
            state_in  = S_DONE;
         end
         // Close the gap left by the hit entry in the recency list.
         S_RD_RD: begin
            if (i_up >= rfill_x) begin
               rfill_in = rfill_ff - 1'b1;
               state_in = S_PUSH;
            end else begin
               cmd.r_rd = 1'b1;
               r_addr   = RAW'(i_up);
               state_in = S_RD_WR;
            end
         end
         S_RD_WR: begin
            cmd.r_wr = 1'b1;
            i_in     = i_up;
            state_in = S_RD_RD;
         end

         // Search the long-term list for the hit key.
         S_FS_RD: begin
            if (i_ff >= ffill_x) begin
               cmd.set_miss = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.f_rd = 1'b1;
               state_in = S_FS_CHK;
            end
         end
         S_FS_CHK: begin
            if (sts.f_match) begin
               cmd.ent_op = ttcc_pkg::ENT_FROM_F;
               state_in   = use_recency ? S_FD_RD : S_F_WB;
            end else begin
               i_in     = i_up;
               state_in = S_FS_RD;
            end
         end
         S_F_WB: begin
            cmd.f_wr  = 1'b1;
            cmd.f_src = ttcc_pkg::SRC_ENT;
            state_in  = S_DONE;
         end
         S_FD_RD: begin
            if (i_up >= ffill_x) begin
               ffill_in = ffill_ff - 1'b1;
               state_in = S_PUSH;
            end else begin
               cmd.f_rd = 1'b1;
               f_addr   = FAW'(i_up);
               state_in = S_FD_WR;
            end
         end
         S_FD_WR: begin
            cmd.f_wr = 1'b1;
            i_in     = i_up;
            state_in = S_FD_RD;
         end

         // Push the working entry to the recency front.
         S_PUSH: begin
            if (rfill_ff >= rlim) begin
               evict_in = 1'b1;
               if (rfill_ff == '0) begin
                  cmd.ev_op = ttcc_pkg::EV_FROM_ENT;
                  i_in      = '0;
                  state_in  = S_FI_RD;
               end else begin
                  cmd.r_rd = 1'b1;
                  r_addr   = RAW'(rfill_x - 1'b1);
                  state_in = S_PE_CAP;
               end
            end else begin
               evict_in = 1'b0;
               i_in     = rfill_x;
               state_in = S_SU_RD;
            end
         end
         S_PE_CAP: begin
            cmd.ev_op = ttcc_pkg::EV_FROM_R;
            i_in      = rfill_x - 1'b1;
            state_in  = S_SU_RD;
         end
         S_SU_RD: begin
            if (i_ff == '0) begin
               cmd.r_wr  = 1'b1;
               cmd.r_src = ttcc_pkg::SRC_ENT;
               if (evict_ff) begin
                  state_in = S_FI_RD;
               end else begin
                  rfill_in = rfill_ff + 1'b1;
                  state_in = S_DONE;
               end
            end else begin
               cmd.r_rd = 1'b1;
               r_addr   = RAW'(i_dn);
               state_in = S_SU_WR;
            end
         end
         S_SU_WR: begin
            cmd.r_wr = 1'b1;
            i_in     = i_dn;
            state_in = S_SU_RD;
         end

         // Ordered insert of the evicted entry into the long-term list.
         S_FI_RD: begin
            if (i_ff >= ffill_x) begin
               pos_in   = ffill_ff;
               state_in = S_FI_PLACE;
            end else begin
               cmd.f_rd = 1'b1;
               state_in = S_FI_CHK;
            end
         end
         S_FI_CHK: begin
            if (sts.ev_ge) begin
               pos_in   = FCW'(i_ff);
               state_in = S_FI_PLACE;
            end else begin
               i_in     = i_up;
               state_in = S_FI_RD;
            end
         end
         S_FI_PLACE: begin
            if (pos_ff < ffill_ff) begin
               if (ffill_ff >= flim) begin
                  grow_in  = 1'b0;
                  cmd.f_rd = 1'b1;
                  f_addr   = FAW'(ffill_x - 1'b1);
                  state_in = S_FI_DROP;
               end else begin
                  grow_in  = 1'b1;
                  i_in     = ffill_x;
                  state_in = S_FU_RD;
               end
            end else if (ffill_ff < flim) begin
               cmd.f_wr  = 1'b1;
               cmd.f_src = ttcc_pkg::SRC_EV;
               f_addr    = FAW'(ffill_x);
               ffill_in  = ffill_ff + 1'b1;
               state_in  = S_DONE;
            end else begin
               cmd.drop_op = ttcc_pkg::DROP_FROM_EV;
               state_in    = S_DONE;
            end
         end
         S_FI_DROP: begin
            cmd.drop_op = ttcc_pkg::DROP_FROM_F;
            i_in        = ffill_x - 1'b1;
            state_in    = S_FU_RD;
         end
         S_FU_RD: begin
            if (i_ff == IW'(pos_ff)) begin
               cmd.f_wr  = 1'b1;
               cmd.f_src = ttcc_pkg::SRC_EV;
               if (grow_ff) begin
                  ffill_in = ffill_ff + 1'b1;
               end
               state_in = S_DONE;
            end else begin
               cmd.f_rd = 1'b1;
               f_addr   = FAW'(i_dn);
               state_in = S_FU_WR;
            end
         end
         S_FU_WR: begin
            cmd.f_wr = 1'b1;
            i_in     = i_dn;
            state_in = S_FU_RD;
         end

         // Hand the result over once the output slot is free.
         S_DONE: begin
            if (sts.slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      pos_ff   <= pos_in;
      evict_ff <= evict_in;
      grow_ff  <= grow_in;
      if (reset) begin
         state_ff <= S_IDLE;
         rfill_ff <= '0;
         ffill_ff <= '0;
      end else begin
         state_ff <= state_in;
         rfill_ff <= rfill_in;
         ffill_ff <= ffill_in;
      end
   end

endmodule

// ----- rtl/core/two_tier_lru_lfu_centroid_cache.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// two_tier_lru_lfu_centroid_cache
// Two-tier replacement policy for cluster centroids: a recency list that
// spills into a hit-count ordered long-term list.
// -----------------------------------------------------------------------------
// Usage:
//   req channel: one beat per item (create a cluster, or hit a named one).
//   rsp channel: one beat per item with the cluster number, its count, any
//   discarded cluster and a status.
//   csr port: APB-style writes of use_recency, recent_limit and
//   frequent_limit, only while no item is in flight.
// Timing: one item at a time. The time an item takes grows with the list
// fills, set by the controller walking each list one entry at a time on its
// single memory port: search, gap close, shift up and ordered insert.
// The next item is taken once the controller is back in idle, even while the
// previous result is still held in the output register.
// Reset empties both lists, restarts cluster numbering at zero and restores
// the register defaults; list contents need no clearing.
// A stalled rsp beat holds; the controller waits for the slot before it
// posts the next result.
// -----------------------------------------------------------------------------
module two_tier_lru_lfu_centroid_cache #(
   parameter int RECENT_DEPTH   = 32,
   parameter int FREQUENT_DEPTH = 32,
   parameter int ID_BITS        = 24,
   parameter int COUNT_BITS     = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  ttcc_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output ttcc_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ttcc_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   localparam int RAW = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
   localparam int FAW = (FREQUENT_DEPTH > 1) ? $clog2(FREQUENT_DEPTH) : 1;

   logic       use_recency_ff, use_recency_in;
   logic [5:0] recent_limit_ff, recent_limit_in;
   logic [5:0] frequent_limit_ff, frequent_limit_in;
   logic [1:0] csr_index;

   ttcc_pkg::cmd_type cmd;
   ttcc_pkg::sts_type sts;
   logic [RAW-1:0]    r_addr;
   logic [FAW-1:0]    f_addr;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];

   // Register writes.
   always_comb begin
      use_recency_in    = use_recency_ff;
      recent_limit_in   = recent_limit_ff;
      frequent_limit_in = frequent_limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (csr_index)
            ttcc_pkg::REG_USE_RECENCY:    use_recency_in    = csr_pwdata[0];
            ttcc_pkg::REG_RECENT_LIMIT:   recent_limit_in   = csr_pwdata[5:0];
            ttcc_pkg::REG_FREQUENT_LIMIT: frequent_limit_in = csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      unique case (csr_index)
         ttcc_pkg::REG_USE_RECENCY:    csr_prdata = {31'd0, use_recency_ff};
         ttcc_pkg::REG_RECENT_LIMIT:   csr_prdata = {26'd0, recent_limit_ff};
         ttcc_pkg::REG_FREQUENT_LIMIT: csr_prdata = {26'd0, frequent_limit_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_recency_ff    <= 1'b1;
         recent_limit_ff   <= 6'd32;
         frequent_limit_ff <= 6'd32;
      end else begin
         use_recency_ff    <= use_recency_in;
         recent_limit_ff   <= recent_limit_in;
         frequent_limit_ff <= frequent_limit_in;
      end
   end

   ttcc_ctrl #(
      .RECENT_DEPTH   (RECENT_DEPTH),
      .FREQUENT_DEPTH (FREQUENT_DEPTH),
      .RAW            (RAW),
      .FAW            (FAW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_op         (req_data.op),
      .req_stall      (req_stall),
      .use_recency    (use_recency_ff),
      .recent_limit   (recent_limit_ff),
      .frequent_limit (frequent_limit_ff),
      .sts            (sts),
      .cmd            (cmd),
      .r_addr         (r_addr),
      .f_addr         (f_addr)
   );

   ttcc_dpath #(
      .RECENT_DEPTH   (RECENT_DEPTH),
      .FREQUENT_DEPTH (FREQUENT_DEPTH),
      .ID_BITS        (ID_BITS),
      .COUNT_BITS     (COUNT_BITS),
      .RAW            (RAW),
      .FAW            (FAW)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .r_addr    (r_addr),
      .f_addr    (f_addr),
      .sts       (sts),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/core/ttcc_checker.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ttcc_checker
// Port-level checks of the centroid cache: result hold, busy behavior
// and result field consistency.
// -----------------------------------------------------------------------------
module ttcc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ttcc_pkg::rsp_type rsp_data
);

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed");

   // An accepted item keeps the block busy in the following cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted without going busy");

   // Reset leaves no result pending.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A result without a discard reports cluster zero as discarded.
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.dropped_valid |-> rsp_data.dropped_cluster == 24'd0)
      else $error("dropped cluster set without a discard");

   // A miss changes nothing, so it carries no count and no discard.
   a_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ttcc_pkg::STATUS_MISS
      |-> rsp_data.hit_count_now == 32'd0 && !rsp_data.dropped_valid)
      else $error("miss result carries a count or discard");

endmodule

bind two_tier_lru_lfu_centroid_cache ttcc_checker u_ttcc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- dv/two_tier_lru_lfu_centroid_cache_test.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// two_tier_lru_lfu_centroid_cache_test
// Self-checking bench for the two-tier centroid cache. A behavioral copy of
// the recency and count-ordered lists predicts every response beat; directed
// tests cover limits, saturation-free wrap paths and misses, then random
// traffic runs under several register settings with random idling.
// -----------------------------------------------------------------------------
module two_tier_lru_lfu_centroid_cache_test;

   localparam int DEPTH = 32;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   ttcc_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   ttcc_pkg::rsp_type rsp_data;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [ttcc_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   two_tier_lru_lfu_centroid_cache DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Shadow copy of the cache state.
   logic [23:0] rec_id [DEPTH];
   logic [31:0] rec_cnt [DEPTH];
   int rec_fill;
   logic [23:0] frq_id [DEPTH];
   logic [31:0] frq_cnt [DEPTH];
   int frq_fill;
   logic [23:0] next_id;
   logic recency_on;
   int recent_lim;
   int frequent_lim;
   logic drop_seen;
   logic [23:0] drop_num;

   ttcc_pkg::rsp_type expected_rsps[$];
   int mismatches;
   int stall_hold;
   logic rsp_random_stall;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic int short_or_long_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Long-term list insert in descending count order.
   task automatic frequent_place(input logic [23:0] id, input logic [31:0] cnt);
      int lim;
      int pos;
      lim = frequent_lim < DEPTH ? frequent_lim : DEPTH;
      pos = frq_fill;
      for (int i = 0; i < frq_fill; i++) begin
         if (cnt >= frq_cnt[i]) begin
            pos = i;
            break;
         end
      end
      if (pos < frq_fill) begin
         if (frq_fill + 1 > lim) begin
            drop_seen = 1'b1;
            drop_num = frq_id[frq_fill-1];
            for (int i = frq_fill - 1; i > pos; i--) begin
               frq_id[i] = frq_id[i-1];
               frq_cnt[i] = frq_cnt[i-1];
            end
         end else begin
            for (int i = frq_fill; i > pos; i--) begin
               frq_id[i] = frq_id[i-1];
               frq_cnt[i] = frq_cnt[i-1];
            end
            frq_fill++;
         end
         frq_id[pos] = id;
         frq_cnt[pos] = cnt;
      end else if (frq_fill < lim) begin
         frq_id[frq_fill] = id;
         frq_cnt[frq_fill] = cnt;
         frq_fill++;
      end else begin
         drop_seen = 1'b1;
         drop_num = id;
      end
   endtask

   // Push to the recency front, spilling the oldest entry when full.
   task automatic recency_push(input logic [23:0] id, input logic [31:0] cnt);
      int lim;
      logic [23:0] ev_id;
      logic [31:0] ev_cnt;
      lim = recent_lim < DEPTH ? recent_lim : DEPTH;
      if (rec_fill + 1 > lim) begin
         if (rec_fill == 0) begin
            ev_id = id;
            ev_cnt = cnt;
         end else begin
            ev_id = rec_id[rec_fill-1];
            ev_cnt = rec_cnt[rec_fill-1];
            for (int i = rec_fill - 1; i > 0; i--) begin
               rec_id[i] = rec_id[i-1];
               rec_cnt[i] = rec_cnt[i-1];
            end
            rec_id[0] = id;
            rec_cnt[0] = cnt;
         end
         frequent_place(ev_id, ev_cnt);
      end else begin
         for (int i = rec_fill; i > 0; i--) begin
            rec_id[i] = rec_id[i-1];
            rec_cnt[i] = rec_cnt[i-1];
         end
         rec_id[0] = id;
         rec_cnt[0] = cnt;
         rec_fill++;
      end
   endtask

   // Work out the response beat for one request beat and update the shadow.
   task automatic predict_cache_result(input ttcc_pkg::req_type rq);
      ttcc_pkg::rsp_type r;
      int idx;
      logic in_r;
      logic in_f;
      logic [31:0] cnt;
      drop_seen = 1'b0;
      drop_num = '0;
      cnt = '0;
      r.status = ttcc_pkg::STATUS_DONE;
      if (rq.op == ttcc_pkg::OP_CREATE) begin
         r.cluster_number = next_id;
         recency_push(next_id, 32'd0);
         next_id = next_id + 24'd1;
      end else begin
         in_r = 1'b0;
         in_f = 1'b0;
         idx = 0;
         r.cluster_number = rq.hit_cluster;
         for (int i = 0; i < rec_fill; i++) begin
            if (rec_id[i] == rq.hit_cluster) begin
               in_r = 1'b1;
               idx = i;
               break;
            end
         end
         if (!in_r) begin
            for (int i = 0; i < frq_fill; i++) begin
               if (frq_id[i] == rq.hit_cluster) begin
                  in_f = 1'b1;
                  idx = i;
                  break;
               end
            end
         end
         if (!in_r && !in_f) begin
            r.status = ttcc_pkg::STATUS_MISS;
         end else if (in_r) begin
            cnt = rec_cnt[idx];
            if (cnt != '1) cnt++;
            if (recency_on) begin
               for (int i = idx; i + 1 < rec_fill; i++) begin
                  rec_id[i] = rec_id[i+1];
                  rec_cnt[i] = rec_cnt[i+1];
               end
               rec_fill--;
               recency_push(rq.hit_cluster, cnt);
            end else begin
               rec_cnt[idx] = cnt;
            end
         end else begin
            cnt = frq_cnt[idx];
            if (cnt != '1) cnt++;
            if (recency_on) begin
               for (int i = idx; i + 1 < frq_fill; i++) begin
                  frq_id[i] = frq_id[i+1];
                  frq_cnt[i] = frq_cnt[i+1];
               end
               frq_fill--;
               recency_push(rq.hit_cluster, cnt);
            end else begin
               frq_cnt[idx] = cnt;
            end
         end
      end
      r.hit_count_now = cnt;
      r.dropped_valid = drop_seen;
      r.dropped_cluster = drop_num;
      expected_rsps.insert(expected_rsps.size(), r);
   endtask

   // Send one request beat and wait until it is taken.
   task automatic send_item(input ttcc_pkg::req_type rq);
      int gap;
      gap = short_or_long_gap();
      repeat (gap) @(posedge clock);
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_cache_result(rq);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_create();
      ttcc_pkg::req_type rq;
      rq.op = ttcc_pkg::OP_CREATE;
      rq.hit_cluster = 24'($urandom);
      send_item(rq);
   endtask

   task automatic send_hit(input logic [23:0] id);
      ttcc_pkg::req_type rq;
      rq.op = ttcc_pkg::OP_HIT;
      rq.hit_cluster = id;
      send_item(rq);
   endtask

   // Pick a cached cluster most of the time, else a random number.
   function automatic logic [23:0] pick_cluster();
      int k;
      k = $urandom_range(0, 9);
      if (k < 5 && rec_fill > 0) return rec_id[$urandom_range(0, rec_fill - 1)];
      if (k < 8 && frq_fill > 0) return frq_id[$urandom_range(0, frq_fill - 1)];
      return 24'($urandom);
   endfunction

   // Wait until all responses are back, then let the block settle.
   task automatic drain();
      int guard;
      guard = 0;
      while (expected_rsps.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      if (expected_rsps.size() != 0) begin
         $display("FAILED: results differ");
         $finish;
      end
      repeat (300) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ttcc_pkg::CSR_ADDR_BITS'({index, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         ttcc_pkg::REG_USE_RECENCY: recency_on = value[0];
         ttcc_pkg::REG_RECENT_LIMIT: recent_lim = int'(value[5:0]);
         default: frequent_lim = int'(value[5:0]);
      endcase
      @(posedge clock);
   endtask

   task automatic set_policy(input logic use_r, input int r_lim, input int f_lim);
      drain();
      write_register(ttcc_pkg::REG_USE_RECENCY, {31'd0, use_r});
      write_register(ttcc_pkg::REG_RECENT_LIMIT, 32'(r_lim));
      write_register(ttcc_pkg::REG_FREQUENT_LIMIT, 32'(f_lim));
   endtask

   // Directed: misses, limit overflow in both tiers, zero limits, big limits.
   task automatic test_directed();
      send_hit(24'hFFFFFF);
      send_hit(24'h000000);
      set_policy(1'b1, 2, 2);
      repeat (3) send_create();
      send_hit(24'd0);
      send_hit(24'd1);
      send_hit(24'd1);
      repeat (3) send_create();
      send_hit(24'd2);
      set_policy(1'b0, 0, 0);
      send_create();
      send_hit(24'd6);
      set_policy(1'b0, 1, 63);
      send_create();
      send_create();
      send_hit(24'd8);
      send_hit(24'd7);
      send_hit(24'hABCDEF);
      set_policy(1'b1, 63, 1);
      send_create();
      send_hit(24'd9);
      send_hit(24'd7);
   endtask

   // Pressure: receiver holds off long so the request side backs up.
   task automatic test_back_pressure();
      drain();
      stall_hold = 400;
      repeat (12) send_create();
      repeat (6) send_hit(pick_cluster());
      drain();
   endtask

   // Random traffic across a spread of settings; limits lowered mid-run.
   task automatic test_random();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_policy(1'b1, 32, 32);
            1: set_policy(1'b0, 4, 6);
            2: set_policy(1'b1, 8, 3);
            3: set_policy(1'b1, 2, 0);
            4: set_policy(1'b0, 63, 63);
            5: set_policy(1'b1, 1, 1);
            6: set_policy(1'b1, $urandom_range(1, 40), $urandom_range(0, 40));
            default: set_policy(1'b1, 5, 32);
         endcase
         for (int n = 0; n < 160; n++) begin
            if ($urandom_range(0, 9) < 4) send_create();
            else send_hit(pick_cluster());
         end
      end
   endtask

   // Stall process: random short or long holds, plus a commanded long hold.
   initial begin
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (stall_hold > 0) begin
            rsp_stall <= 1'b1;
            stall_hold--;
         end else if (rsp_random_stall && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Response checker.
   always @(posedge clock) begin
      ttcc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %p", rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p got %p", want, rsp_data);
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      mismatches = 0;
      stall_hold = 0;
      rsp_random_stall = 1'b1;
      rec_fill = 0;
      frq_fill = 0;
      next_id = '0;
      recency_on = 1'b1;
      recent_lim = 32;
      frequent_lim = 32;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_back_pressure();
      test_random();
      rsp_random_stall = 1'b0;
      drain();
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- two_tier_lru_lfu_centroid_cache.f -----
rtl/core/ttcc_pkg.sv
rtl/core/ttcc_dpath.sv
rtl/core/ttcc_ctrl.sv
rtl/core/two_tier_lru_lfu_centroid_cache.sv
rtl/core/ttcc_checker.sv
dv/two_tier_lru_lfu_centroid_cache_test.sv
